// File: rtl/assert_macros.svh
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// File: rtl/lpht_pkg.sv
package lpht_pkg;

  localparam int CFG_W = 10;
  localparam logic [CFG_W-1:0] FILL_LIMIT_RST = 10'd716;

  localparam logic [31:0] EMPTY_KEY = 32'hFFFF_FFFF;
  localparam logic [31:0] MIX_C1    = 32'h7FEB_352D;
  localparam logic [31:0] MIX_C2    = 32'h846C_A68B;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RESERVED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_HASH,
    S_CHECK,
    S_DONE
  } state_t;

endpackage

// File: rtl/lpht_ram.sv
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/linear_probe_hash_table.sv
// Channel | Dir | Handshake             | Payload
// in_     | in  | in_tvalid / in_tready | tuser: op; tdata: key, value
// out_    | out | out_tvalid/out_tready | tuser: found, status; tdata: value_out
// cfg_    | in  | cfg_valid / cfg_ready | data: fill_limit (always ready)
//
// One request at a time: S_MUL1, S_MUL2, S_HASH, one S_CHECK per probe, then S_DONE,
// which registers the result word (reserved key: S_DONE only); S_IDLE then takes the next.
// Probing reads one slot per cycle from the key and value RAMs (one read port).
// After reset a clearing pass writes the empty key to every slot with in_tready low.
// SLOTS must be a power of two (home slot is a mask).
// A result waiting on out_tready holds the next request in its final state.
`include "assert_macros.svh"

module linear_probe_hash_table #(
  parameter int SLOTS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic                       in_tuser,   // [0] op
  input  logic [63:0]                in_tdata,   // [31:0] key, [63:32] value
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [2:0]                 out_tuser,  // [0] found, [2:1] status
  output logic [31:0]                out_tdata,  // [31:0] value_out
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lpht_pkg::CFG_W-1:0] cfg_data
);

  import lpht_pkg::*;

  localparam int ADDR_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [ADDR_W-1:0] SLOT_LAST = ADDR_W'(SLOTS - 1);
  localparam logic [CMP_W-1:0]  CAP       = CMP_W'(SLOTS - 1);

  state_t state_r, state_nxt;

  logic              op_r;
  logic [31:0]       key_r, val_r;
  logic [31:0]       m1_r, m2_r;
  logic [ADDR_W-1:0] idx_r, probe_cnt_r, clr_addr_r;
  logic [CNT_W-1:0]  entry_count_r;
  logic [CFG_W-1:0]  fill_limit_r;
  logic              res_found_r;
  logic [31:0]       res_value_r;
  status_t           res_status_r;
  logic              out_tvalid_r, out_found_r;
  logic [31:0]       out_value_r;
  status_t           out_status_r;

  logic [31:0]       x1, mul1, x2, mul2, h;
  logic [ADDR_W-1:0] home, idx_inc, rd_addr, kwr_addr;
  logic [31:0]       key_rdata, val_rdata, kwr_data;
  logic              kwr_en, vwr_en, cnt_inc;
  logic              in_acc, out_free, is_empty, is_hit, exhausted, probe_end, full;
  logic [CMP_W-1:0]  limit, fl_ext;

  // mixing hash, one multiply per cycle
  assign x1   = key_r ^ (key_r >> 16);
  assign mul1 = x1 * MIX_C1;
  assign x2   = m1_r ^ (m1_r >> 15);
  assign mul2 = x2 * MIX_C2;
  assign h    = m2_r ^ (m2_r >> 16);
  assign home = h[ADDR_W-1:0];

  assign idx_inc = (idx_r == SLOT_LAST) ? '0 : idx_r + 1'b1;

  assign is_empty  = (key_rdata == EMPTY_KEY);
  assign is_hit    = !is_empty && (key_rdata == key_r);
  assign exhausted = !is_empty && !is_hit && (probe_cnt_r == SLOT_LAST);
  assign probe_end = is_empty || is_hit || exhausted;

  assign fl_ext = CMP_W'(fill_limit_r);
  assign limit  = (fl_ext > CAP) ? CAP : fl_ext;
  assign full   = (CMP_W'(entry_count_r) >= limit);

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_addr_r == SLOT_LAST) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tdata[31:0] == EMPTY_KEY) ? S_DONE : S_MUL1;
        end
      end
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_HASH;
      S_HASH:  state_nxt = S_CHECK;
      S_CHECK: if (probe_end) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // memory control
  always_comb begin
    in_tready = 1'b0;
    rd_addr   = idx_inc;
    kwr_en    = 1'b0;
    kwr_addr  = idx_r;
    kwr_data  = key_r;
    vwr_en    = 1'b0;
    cnt_inc   = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        kwr_en   = 1'b1;
        kwr_addr = clr_addr_r;
        kwr_data = EMPTY_KEY;
      end
      S_IDLE: in_tready = 1'b1;
      S_HASH: rd_addr = home;
      S_CHECK: begin
        if (op_r == OP_INSERT) begin
          if (is_hit) begin
            vwr_en = 1'b1;
          end else if (is_empty && !full) begin
            kwr_en  = 1'b1;
            vwr_en  = 1'b1;
            cnt_inc = 1'b1;
          end
        end
      end
      S_MUL1, S_MUL2, S_DONE: ;
      default: ;
    endcase
  end

  lpht_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (kwr_en),
    .waddr (kwr_addr),
    .wdata (kwr_data),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  lpht_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_val_ram (
    .clk   (clk),
    .we    (vwr_en),
    .waddr (idx_r),
    .wdata (val_r),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_addr_r    <= '0;
      entry_count_r <= '0;
      fill_limit_r  <= FILL_LIMIT_RST;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cnt_inc) begin
        entry_count_r <= entry_count_r + 1'b1;
      end
      if (cfg_valid) begin
        fill_limit_r <= cfg_data;
      end
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // request and result words
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r         <= in_tuser;
          key_r        <= in_tdata[31:0];
          val_r        <= in_tdata[63:32];
          res_found_r  <= 1'b0;
          res_value_r  <= '0;
          res_status_r <= ST_RESERVED;
        end
      end
      S_MUL1: m1_r <= mul1;
      S_MUL2: m2_r <= mul2;
      S_HASH: begin
        idx_r       <= home;
        probe_cnt_r <= '0;
      end
      S_CHECK: begin
        if (probe_end) begin
          res_found_r  <= is_hit;
          res_value_r  <= (is_hit && op_r == OP_LOOKUP) ? val_rdata : '0;
          res_status_r <= (op_r == OP_INSERT && !is_hit && (full || exhausted)) ?
                          ST_FULL : ST_OK;
        end else begin
          idx_r       <= idx_inc;
          probe_cnt_r <= probe_cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_found_r  <= res_found_r;
          out_value_r  <= res_value_r;
          out_status_r <= res_status_r;
        end
      end
      S_CLEAR: ;
      default: ;
    endcase
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_status_r, out_found_r};

  `ASSERT_CLK(a_count_capped, CMP_W'(entry_count_r) <= CAP, "count above capacity")
  `ASSERT_CLK(a_count_step, entry_count_r - $past(entry_count_r) <= CNT_W'(1), "count jump")
  `ASSERT_NEVER(a_no_empty_wr, kwr_en && state_r != S_CLEAR && kwr_data == EMPTY_KEY, "empty key")
  `ASSERT_NEVER(a_no_result_in_clear, state_r == S_CLEAR && out_tvalid_r, "word while clearing")

endmodule
